@@ hw/rtl/jwt_pkg.sv @@
// shared types and code constants for the jvm to wasm translator
`timescale 1ns / 1ps

package jwt_pkg;

   localparam int MaxBlocksDefault = 1024;
   localparam int QueueDepth = 4;
   localparam int ValWidth = 18;
   localparam int LocalWidth = 16;
   localparam int BlockWidth = 10;
   localparam int TokIdxWidth = 4;

   // wasm code bytes
   localparam logic [7:0] WASM_DROP      = 8'h1a;
   localparam logic [7:0] WASM_SELECT    = 8'h1b;
   localparam logic [7:0] WASM_BR        = 8'h0c;
   localparam logic [7:0] WASM_RETURN    = 8'h0f;
   localparam logic [7:0] WASM_LOCAL_GET = 8'h20;
   localparam logic [7:0] WASM_LOCAL_SET = 8'h21;
   localparam logic [7:0] WASM_LOCAL_TEE = 8'h22;
   localparam logic [7:0] WASM_I32_CONST = 8'h41;
   localparam logic [7:0] WASM_I32_EQ    = 8'h46;
   localparam logic [7:0] WASM_I32_NE    = 8'h47;
   localparam logic [7:0] WASM_I32_LT_S  = 8'h48;
   localparam logic [7:0] WASM_I32_GT_S  = 8'h4a;
   localparam logic [7:0] WASM_I32_LE_S  = 8'h4c;
   localparam logic [7:0] WASM_I32_GE_S  = 8'h4e;
   localparam logic [7:0] WASM_I32_ADD   = 8'h6a;
   localparam logic [7:0] WASM_I32_SUB   = 8'h6b;
   localparam logic [7:0] WASM_I32_MUL   = 8'h6c;
   localparam logic [7:0] WASM_I32_DIV_S = 8'h6d;
   localparam logic [7:0] WASM_I32_REM_S = 8'h6f;
   localparam logic [7:0] WASM_I32_AND   = 8'h71;
   localparam logic [7:0] WASM_I32_OR    = 8'h72;
   localparam logic [7:0] WASM_I32_XOR   = 8'h73;
   localparam logic [7:0] WASM_I32_SHL   = 8'h74;
   localparam logic [7:0] WASM_I32_SHR_S = 8'h75;
   localparam logic [7:0] WASM_I32_SHR_U = 8'h76;

   // register indexes
   localparam logic CSR_LOCAL_COUNT = 1'b0;

   typedef logic signed [ValWidth-1:0] val_type;

   typedef enum logic [3:0] {
      K_BAD, K_CONST, K_LOAD, K_STORE, K_DUP, K_SINGLE, K_NEG,
      K_IINC, K_NARROW, K_CHAR, K_GOTO, K_IF
   } op_kind_type;

   typedef enum logic [1:0] {
      T_LIT, T_ULEB, T_CONST
   } tok_kind_type;

   typedef struct packed {
      op_kind_type           kind;
      logic [7:0]            code;
      val_type               val;
      val_type               val2;
      logic [BlockWidth-1:0] tgt;
      logic [BlockWidth-1:0] fall;
      logic                  zero;
   } entry_type;

   typedef struct packed {
      tok_kind_type kind;
      logic [7:0]   lit;
      val_type      value;
      logic         last;
   } token_type;

endpackage

@@ hw/rtl/jwt_front.sv @@
// front end: accepts instruction words and classifies the opcode
`timescale 1ns / 1ps

module jwt_front
   import jwt_pkg::*;
#(
   parameter int MAX_BLOCKS = MaxBlocksDefault
) (
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic        q_full,
   output logic        q_push,
   output entry_type   q_entry
);

   localparam logic [7:0] JVM_ICONST_M1 = 8'h02;
   localparam logic [7:0] JVM_ICONST_0  = 8'h03;
   localparam logic [7:0] JVM_ICONST_1  = 8'h04;
   localparam logic [7:0] JVM_ICONST_2  = 8'h05;
   localparam logic [7:0] JVM_ICONST_3  = 8'h06;
   localparam logic [7:0] JVM_ICONST_4  = 8'h07;
   localparam logic [7:0] JVM_ICONST_5  = 8'h08;
   localparam logic [7:0] JVM_BIPUSH    = 8'h10;
   localparam logic [7:0] JVM_SIPUSH    = 8'h11;
   localparam logic [7:0] JVM_ILOAD     = 8'h15;
   localparam logic [7:0] JVM_ILOAD_0   = 8'h1a;
   localparam logic [7:0] JVM_ILOAD_1   = 8'h1b;
   localparam logic [7:0] JVM_ILOAD_2   = 8'h1c;
   localparam logic [7:0] JVM_ILOAD_3   = 8'h1d;
   localparam logic [7:0] JVM_ISTORE    = 8'h36;
   localparam logic [7:0] JVM_ISTORE_0  = 8'h3b;
   localparam logic [7:0] JVM_ISTORE_1  = 8'h3c;
   localparam logic [7:0] JVM_ISTORE_2  = 8'h3d;
   localparam logic [7:0] JVM_ISTORE_3  = 8'h3e;
   localparam logic [7:0] JVM_POP       = 8'h57;
   localparam logic [7:0] JVM_DUP       = 8'h59;
   localparam logic [7:0] JVM_IADD      = 8'h60;
   localparam logic [7:0] JVM_ISUB      = 8'h64;
   localparam logic [7:0] JVM_IMUL      = 8'h68;
   localparam logic [7:0] JVM_IDIV      = 8'h6c;
   localparam logic [7:0] JVM_IREM      = 8'h70;
   localparam logic [7:0] JVM_INEG      = 8'h74;
   localparam logic [7:0] JVM_ISHL      = 8'h78;
   localparam logic [7:0] JVM_ISHR      = 8'h7a;
   localparam logic [7:0] JVM_IUSHR     = 8'h7c;
   localparam logic [7:0] JVM_IAND      = 8'h7e;
   localparam logic [7:0] JVM_IOR       = 8'h80;
   localparam logic [7:0] JVM_IXOR      = 8'h82;
   localparam logic [7:0] JVM_IINC      = 8'h84;
   localparam logic [7:0] JVM_I2B       = 8'h91;
   localparam logic [7:0] JVM_I2C       = 8'h92;
   localparam logic [7:0] JVM_I2S       = 8'h93;
   localparam logic [7:0] JVM_IFEQ      = 8'h99;
   localparam logic [7:0] JVM_IFNE      = 8'h9a;
   localparam logic [7:0] JVM_IFLT      = 8'h9b;
   localparam logic [7:0] JVM_IFGE      = 8'h9c;
   localparam logic [7:0] JVM_IFGT      = 8'h9d;
   localparam logic [7:0] JVM_IFLE      = 8'h9e;
   localparam logic [7:0] JVM_ICMPEQ    = 8'h9f;
   localparam logic [7:0] JVM_ICMPNE    = 8'ha0;
   localparam logic [7:0] JVM_ICMPLT    = 8'ha1;
   localparam logic [7:0] JVM_ICMPGE    = 8'ha2;
   localparam logic [7:0] JVM_ICMPGT    = 8'ha3;
   localparam logic [7:0] JVM_ICMPLE    = 8'ha4;
   localparam logic [7:0] JVM_GOTO      = 8'ha7;
   localparam logic [7:0] JVM_IRETURN   = 8'hac;

   localparam int LimitWidth = 17;
   localparam logic [LimitWidth-1:0] BlockLimit = LimitWidth'(MAX_BLOCKS - 1);

   logic [7:0]            opcode;
   logic [7:0]            operand_a;
   logic [7:0]            operand_b;
   logic [BlockWidth-1:0] target_block;
   logic [BlockWidth-1:0] fall_block;
   logic [7:0]            cmp_sel;

   function automatic logic [BlockWidth-1:0] clamp_block(input logic [BlockWidth-1:0] blk);
      logic [LimitWidth-1:0] wide;
      wide = LimitWidth'(blk);
      return (wide > BlockLimit) ? BlockLimit[BlockWidth-1:0] : blk;
   endfunction

   function automatic logic [7:0] cmp_code(input logic [7:0] k);
      logic [7:0] code;
      unique case (k)
         8'd0:    code = WASM_I32_EQ;
         8'd1:    code = WASM_I32_NE;
         8'd2:    code = WASM_I32_LT_S;
         8'd3:    code = WASM_I32_GE_S;
         8'd4:    code = WASM_I32_GT_S;
         default: code = WASM_I32_LE_S;
      endcase
      return code;
   endfunction

   assign opcode       = req_tdata[7:0];
   assign operand_a    = req_tdata[15:8];
   assign operand_b    = req_tdata[23:16];
   assign target_block = req_tdata[33:24];
   assign fall_block   = req_tdata[43:34];

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   assign cmp_sel = (opcode <= JVM_IFLE) ? 8'(opcode - JVM_IFEQ) : 8'(opcode - JVM_ICMPEQ);

   always_comb begin
      q_entry.kind = K_BAD;
      q_entry.code = opcode;
      q_entry.val  = '0;
      q_entry.val2 = {{(ValWidth-8){operand_b[7]}}, operand_b};
      q_entry.tgt  = clamp_block(target_block);
      q_entry.fall = clamp_block(fall_block);
      q_entry.zero = 1'b0;
      unique case (opcode)
         JVM_ICONST_M1: begin
            q_entry.kind = K_CONST;
            q_entry.val  = '1;
         end
         JVM_ICONST_0, JVM_ICONST_1, JVM_ICONST_2, JVM_ICONST_3,
         JVM_ICONST_4, JVM_ICONST_5: begin
            q_entry.kind = K_CONST;
            q_entry.val  = ValWidth'(8'(opcode - JVM_ICONST_0));
         end
         JVM_BIPUSH: begin
            q_entry.kind = K_CONST;
            q_entry.val  = {{(ValWidth-8){operand_a[7]}}, operand_a};
         end
         JVM_SIPUSH: begin
            q_entry.kind = K_CONST;
            q_entry.val  = {{(ValWidth-16){operand_a[7]}}, operand_a, operand_b};
         end
         JVM_ILOAD_0, JVM_ILOAD_1, JVM_ILOAD_2, JVM_ILOAD_3: begin
            q_entry.kind = K_LOAD;
            q_entry.val  = ValWidth'(8'(opcode - JVM_ILOAD_0));
         end
         JVM_ILOAD: begin
            q_entry.kind = K_LOAD;
            q_entry.val  = ValWidth'(operand_a);
         end
         JVM_ISTORE_0, JVM_ISTORE_1, JVM_ISTORE_2, JVM_ISTORE_3: begin
            q_entry.kind = K_STORE;
            q_entry.val  = ValWidth'(8'(opcode - JVM_ISTORE_0));
         end
         JVM_ISTORE: begin
            q_entry.kind = K_STORE;
            q_entry.val  = ValWidth'(operand_a);
         end
         JVM_DUP: q_entry.kind = K_DUP;
         JVM_POP: begin
            q_entry.kind = K_SINGLE;
            q_entry.code = WASM_DROP;
         end
         JVM_IADD: begin
            q_entry.kind = K_SINGLE;
            q_entry.code = WASM_I32_ADD;
         end
         JVM_ISUB: begin
            q_entry.kind = K_SINGLE;
            q_entry.code = WASM_I32_SUB;
         end
         JVM_IMUL: begin
            q_entry.kind = K_SINGLE;
            q_entry.code = WASM_I32_MUL;
         end
         JVM_IDIV: begin
            q_entry.kind = K_SINGLE;
            q_entry.code = WASM_I32_DIV_S;
         end
         JVM_IREM: begin
            q_entry.kind = K_SINGLE;
            q_entry.code = WASM_I32_REM_S;
         end
         JVM_IAND: begin
            q_entry.kind = K_SINGLE;
            q_entry.code = WASM_I32_AND;
         end
         JVM_IOR: begin
            q_entry.kind = K_SINGLE;
            q_entry.code = WASM_I32_OR;
         end
         JVM_IXOR: begin
            q_entry.kind = K_SINGLE;
            q_entry.code = WASM_I32_XOR;
         end
         JVM_ISHL: begin
            q_entry.kind = K_SINGLE;
            q_entry.code = WASM_I32_SHL;
         end
         JVM_ISHR: begin
            q_entry.kind = K_SINGLE;
            q_entry.code = WASM_I32_SHR_S;
         end
         JVM_IUSHR: begin
            q_entry.kind = K_SINGLE;
            q_entry.code = WASM_I32_SHR_U;
         end
         JVM_IRETURN: begin
            q_entry.kind = K_SINGLE;
            q_entry.code = WASM_RETURN;
         end
         JVM_INEG: q_entry.kind = K_NEG;
         JVM_IINC: begin
            q_entry.kind = K_IINC;
            q_entry.val  = ValWidth'(operand_a);
         end
         JVM_I2B: begin
            q_entry.kind = K_NARROW;
            q_entry.val  = ValWidth'(24);
         end
         JVM_I2S: begin
            q_entry.kind = K_NARROW;
            q_entry.val  = ValWidth'(16);
         end
         JVM_I2C: q_entry.kind = K_CHAR;
         JVM_GOTO: q_entry.kind = K_GOTO;
         JVM_IFEQ, JVM_IFNE, JVM_IFLT, JVM_IFGE, JVM_IFGT, JVM_IFLE,
         JVM_ICMPEQ, JVM_ICMPNE, JVM_ICMPLT, JVM_ICMPGE, JVM_ICMPGT, JVM_ICMPLE: begin
            q_entry.kind = K_IF;
            q_entry.code = cmp_code(cmp_sel);
            q_entry.zero = (opcode <= JVM_IFLE);
         end
         default: q_entry.kind = K_BAD;
      endcase
   end

endmodule

@@ hw/rtl/jwt_queue.sv @@
// short queue of classified instructions between front and back end
`timescale 1ns / 1ps

module jwt_queue
   import jwt_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output logic      head_valid,
   output logic      full,
   output entry_type head
);

   localparam int PtrWidth = $clog2(QueueDepth);
   localparam int CountWidth = $clog2(QueueDepth + 1);

   entry_type             mem_ff [QueueDepth];
   logic [PtrWidth-1:0]   wr_ff, wr_in;
   logic [PtrWidth-1:0]   rd_ff, rd_in;
   logic [CountWidth-1:0] count_ff, count_in;

   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == CountWidth'(QueueDepth));
   assign head       = mem_ff[rd_ff];

   always_comb begin
      wr_in    = push ? PtrWidth'(wr_ff + 1'b1) : wr_ff;
      rd_in    = pop ? PtrWidth'(rd_ff + 1'b1) : rd_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = CountWidth'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CountWidth'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

endmodule

@@ hw/rtl/jwt_back.sv @@
// back end: walks the token list of an instruction and emits leb128 bytes
`timescale 1ns / 1ps

module jwt_back
   import jwt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  entry_type             head,
   output logic                  pop,
   input  logic [LocalWidth-1:0] local_count,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,
   output logic                  rsp_tlast,
   output logic                  rsp_tuser
);

   logic [TokIdxWidth-1:0] tok_ff, tok_in;
   logic                   started_ff, started_in;
   val_type                rem_ff, rem_in;
   logic                   out_valid_ff, out_valid_in;
   logic [7:0]             out_byte_ff, out_byte_in;
   logic                   out_last_ff, out_last_in;
   logic                   out_bad_ff, out_bad_in;

   logic [TokIdxWidth-1:0] eidx;
   token_type              tok;
   val_type                tmp_val;
   val_type                bb_val;
   val_type                cur;
   val_type                nxt;
   logic                   sleb_done;
   logic                   uleb_done;
   logic                   tok_done;
   logic                   prefix;
   logic [7:0]             emit_byte;
   logic                   step;

   function automatic token_type mk(input tok_kind_type k, input logic [7:0] lit,
                                    input val_type v, input logic last);
      token_type t;
      t.kind  = k;
      t.lit   = lit;
      t.value = v;
      t.last  = last;
      return t;
   endfunction

   assign tmp_val = ValWidth'(17'(local_count) + 17'd1);
   assign bb_val  = ValWidth'(local_count);

   always_comb begin
      eidx = tok_ff;
      if (head.kind == K_IF && !head.zero) begin
         eidx = TokIdxWidth'(tok_ff + 1'b1);
      end
   end

   always_comb begin
      tok = mk(T_LIT, head.code, '0, 1'b1);
      unique case (head.kind)
         K_CONST: tok = mk(T_CONST, 8'h00, head.val, 1'b1);
         K_LOAD: begin
            if (eidx == 4'd0) tok = mk(T_LIT, WASM_LOCAL_GET, '0, 1'b0);
            else              tok = mk(T_ULEB, 8'h00, head.val, 1'b1);
         end
         K_STORE: begin
            if (eidx == 4'd0) tok = mk(T_LIT, WASM_LOCAL_SET, '0, 1'b0);
            else              tok = mk(T_ULEB, 8'h00, head.val, 1'b1);
         end
         K_DUP: begin
            unique case (eidx)
               4'd0:    tok = mk(T_LIT, WASM_LOCAL_TEE, '0, 1'b0);
               4'd1:    tok = mk(T_ULEB, 8'h00, tmp_val, 1'b0);
               4'd2:    tok = mk(T_LIT, WASM_LOCAL_GET, '0, 1'b0);
               default: tok = mk(T_ULEB, 8'h00, tmp_val, 1'b1);
            endcase
         end
         K_NEG: begin
            if (eidx == 4'd0) tok = mk(T_CONST, 8'h00, '1, 1'b0);
            else              tok = mk(T_LIT, WASM_I32_MUL, '0, 1'b1);
         end
         K_IINC: begin
            unique case (eidx)
               4'd0:    tok = mk(T_LIT, WASM_LOCAL_GET, '0, 1'b0);
               4'd1:    tok = mk(T_ULEB, 8'h00, head.val, 1'b0);
               4'd2:    tok = mk(T_CONST, 8'h00, head.val2, 1'b0);
               4'd3:    tok = mk(T_LIT, WASM_I32_ADD, '0, 1'b0);
               4'd4:    tok = mk(T_LIT, WASM_LOCAL_SET, '0, 1'b0);
               default: tok = mk(T_ULEB, 8'h00, head.val, 1'b1);
            endcase
         end
         K_NARROW: begin
            unique case (eidx)
               4'd0:    tok = mk(T_CONST, 8'h00, head.val, 1'b0);
               4'd1:    tok = mk(T_LIT, WASM_I32_SHL, '0, 1'b0);
               4'd2:    tok = mk(T_CONST, 8'h00, head.val, 1'b0);
               default: tok = mk(T_LIT, WASM_I32_SHR_S, '0, 1'b1);
            endcase
         end
         K_CHAR: begin
            if (eidx == 4'd0) tok = mk(T_CONST, 8'h00, ValWidth'(17'h0ffff), 1'b0);
            else              tok = mk(T_LIT, WASM_I32_AND, '0, 1'b1);
         end
         K_GOTO: begin
            unique case (eidx)
               4'd0:    tok = mk(T_CONST, 8'h00, ValWidth'(head.tgt), 1'b0);
               4'd1:    tok = mk(T_LIT, WASM_LOCAL_SET, '0, 1'b0);
               4'd2:    tok = mk(T_ULEB, 8'h00, bb_val, 1'b0);
               4'd3:    tok = mk(T_LIT, WASM_BR, '0, 1'b0);
               default: tok = mk(T_ULEB, 8'h00, ValWidth'(1), 1'b1);
            endcase
         end
         K_IF: begin
            unique case (eidx)
               4'd0:    tok = mk(T_CONST, 8'h00, '0, 1'b0);
               4'd1:    tok = mk(T_LIT, head.code, '0, 1'b0);
               4'd2:    tok = mk(T_LIT, WASM_LOCAL_SET, '0, 1'b0);
               4'd3:    tok = mk(T_ULEB, 8'h00, tmp_val, 1'b0);
               4'd4:    tok = mk(T_CONST, 8'h00, ValWidth'(head.tgt), 1'b0);
               4'd5:    tok = mk(T_CONST, 8'h00, ValWidth'(head.fall), 1'b0);
               4'd6:    tok = mk(T_LIT, WASM_LOCAL_GET, '0, 1'b0);
               4'd7:    tok = mk(T_ULEB, 8'h00, tmp_val, 1'b0);
               4'd8:    tok = mk(T_LIT, WASM_SELECT, '0, 1'b0);
               4'd9:    tok = mk(T_LIT, WASM_LOCAL_SET, '0, 1'b0);
               4'd10:   tok = mk(T_ULEB, 8'h00, bb_val, 1'b0);
               4'd11:   tok = mk(T_LIT, WASM_BR, '0, 1'b0);
               default: tok = mk(T_ULEB, 8'h00, ValWidth'(1), 1'b1);
            endcase
         end
         default: tok = mk(T_LIT, head.code, '0, 1'b1);
      endcase
   end

   // leb128 digit from the running remainder
   assign cur       = started_ff ? rem_ff : tok.value;
   assign nxt       = cur >>> 7;
   assign uleb_done = (nxt == '0);
   assign sleb_done = ((nxt == '0) && !cur[6]) || ((nxt == '1) && cur[6]);
   assign prefix    = (tok.kind == T_CONST) && !started_ff;

   always_comb begin
      priority if (tok.kind == T_LIT) begin
         emit_byte = tok.lit;
         tok_done  = 1'b1;
      end else if (prefix) begin
         emit_byte = WASM_I32_CONST;
         tok_done  = 1'b0;
      end else if (tok.kind == T_ULEB) begin
         emit_byte = {!uleb_done, cur[6:0]};
         tok_done  = uleb_done;
      end else begin
         emit_byte = {!sleb_done, cur[6:0]};
         tok_done  = sleb_done;
      end
   end

   assign step = head_valid && (!out_valid_ff || rsp_tready);
   assign pop  = step && tok_done && tok.last;

   always_comb begin
      tok_in       = tok_ff;
      started_in   = started_ff;
      rem_in       = rem_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_bad_in   = out_bad_ff;
      if (step) begin
         out_valid_in = 1'b1;
         out_byte_in  = emit_byte;
         out_last_in  = tok_done && tok.last;
         out_bad_in   = (head.kind == K_BAD);
         if (tok_done) begin
            started_in = 1'b0;
            tok_in     = tok.last ? '0 : TokIdxWidth'(tok_ff + 1'b1);
         end else begin
            started_in = 1'b1;
            rem_in     = prefix ? cur : nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff       <= '0;
         started_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         tok_ff       <= tok_in;
         started_ff   <= started_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      out_bad_ff  <= out_bad_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_bad_ff;

endmodule

@@ hw/rtl/jvm_to_wasm_instruction_translator.sv @@
// Translates one JVM integer instruction per input word into its WebAssembly
// code bytes, one byte per output word, with tlast on the final byte and tuser
// marking the single error word of an unsupported opcode (which carries the
// opcode). The front end decodes an instruction in the cycle it is accepted
// and places it in a four-entry queue; it takes a new word every cycle while
// the queue has room. The back end serializer emits one byte per clock unless
// rsp_tready holds it off; an instruction yields 1 to 24 bytes, typically 2 to
// 6. Sustained throughput is set by that serializer. The local_count register
// (address 0) sets the dispatch local (local_count) and temp local
// (local_count + 1); write it only while the block is idle.
`timescale 1ns / 1ps

module jvm_to_wasm_instruction_translator
   import jwt_pkg::*;
#(
   parameter int MAX_BLOCKS = MaxBlocksDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // opcode[7:0], operand_a[15:8], operand_b[23:16], target_block[33:24],
   // fall_block[43:34], zero fill [47:44]
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_byte[7:0]
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast,
   // unsupported[0]
   output logic        rsp_tuser,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [LocalWidth-1:0] local_count_ff, local_count_in;
   logic                  csr_write;
   logic                  q_full;
   logic                  q_push;
   logic                  q_pop;
   logic                  q_valid;
   entry_type             q_entry;
   entry_type             q_head;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      local_count_in = local_count_ff;
      if (csr_write && csr_paddr[2] == CSR_LOCAL_COUNT) begin
         local_count_in = csr_pwdata[LocalWidth-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == CSR_LOCAL_COUNT) begin
         csr_prdata = 32'(local_count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_count_ff <= '0;
      end else begin
         local_count_ff <= local_count_in;
      end
   end

   jwt_front #(
      .MAX_BLOCKS(MAX_BLOCKS)
   ) u_front (
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (q_entry)
   );

   jwt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_entry(q_entry),
      .pop       (q_pop),
      .head_valid(q_valid),
      .full      (q_full),
      .head      (q_head)
   );

   jwt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_valid),
      .head       (q_head),
      .pop        (q_pop),
      .local_count(local_count_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
